// ===== hw/rtl/i2c_master_register_access_assert.svh =====
// Assertion macros for the register-access I2C master
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2CM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define I2CM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/i2cm_pkg.sv =====
// -----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the register-access I2C master.
// -----------------------------------------------------------------------------
`default_nettype none
package i2cm_pkg;
    localparam logic [1:0] K_TICK  = 2'd0;
    localparam logic [1:0] K_WRITE = 2'd1;
    localparam logic [1:0] K_READ  = 2'd2;
    localparam logic [1:0] K_LOAD  = 2'd3;
    localparam logic       CFG_TPU = 1'b0;
    localparam logic       CFG_ATO = 1'b1;

    typedef enum logic [3:0] {
        P_IDLE, P_START_HI, P_START_LO, P_BIT_SET, P_BIT_HIGH, P_BIT_LOW,
        P_ACK_REL, P_ACK_RISE, P_ACK_POLL, P_RD_LOW, P_RD_HIGH, P_AK_SET,
        P_AK_HIGH, P_STOP_LO, P_STOP_HI
    } t_phase;

    typedef enum logic [3:0] {
        S_START1, S_ADDR_W, S_ACK_ADDR, S_REG, S_ACK_REG, S_WDATA, S_ACK_DATA,
        S_START2, S_ADDR_R, S_ACK_RADDR, S_RDATA, S_RACK, S_STOP
    } t_stage;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rbyte;
        logic       rvalid;
        logic       busy;
        logic       done;
        logic       err;
    } t_res;
endpackage
`default_nettype wire

// ===== hw/rtl/i2cm_ram.sv =====
// -----------------------------------------------------------------------------
// i2cm_ram
// Generic single-port-write RAM with registered read.
// -----------------------------------------------------------------------------
`default_nettype none
module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/i2cm_queue.sv =====
// -----------------------------------------------------------------------------
// i2cm_queue
// Two-entry queue of accepted transactions between front end and engine.
// -----------------------------------------------------------------------------
`default_nettype none
module i2cm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire i2cm_pkg::t_item i_item,
    input  wire logic           i_pop,
    output logic                o_valid,
    output logic                o_full,
    output i2cm_pkg::t_item     o_item
);
    import i2cm_pkg::*;
    t_item      r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0; r_wr <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_q[r_wr] <= i_item;
                r_wr <= ~r_wr;
            end
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_item  = r_q[r_rd];
endmodule
`default_nettype wire

// ===== hw/rtl/i2cm_engine.sv =====
// -----------------------------------------------------------------------------
// i2cm_engine
// Bus engine: executes one transaction per cycle in which i_go is set, against the bit sequencer.
// Write-buffer bytes are prefetched so each data byte is ready when its step begins.
// -----------------------------------------------------------------------------
`default_nettype none
module i2cm_engine #(
    parameter int WRITE_DEPTH = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_go,
    input  wire i2cm_pkg::t_item i_item,
    input  wire logic [15:0]     i_tpu,
    input  wire logic [7:0]      i_ato,
    output i2cm_pkg::t_res       o_res
);
    import i2cm_pkg::*;
    localparam int AW = WRITE_DEPTH > 1 ? $clog2(WRITE_DEPTH) : 1;
    localparam int CW = $clog2(WRITE_DEPTH + 1);

    t_phase r_phase, n_phase;
    t_stage r_stage, n_stage, r_resume, n_resume;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_byte, n_byte, r_shift, n_shift, r_poll, n_poll;
    logic [15:0] r_timer, n_timer;
    logic [2:0]  r_delay, n_delay;
    logic [CW-1:0] r_load, n_load;
    logic [6:0]  r_dev, n_dev;
    logic [7:0]  r_reg, n_reg, r_len, n_len;
    logic        r_rd, n_rd, r_scl, n_scl, r_sda, n_sda, r_fail, n_fail;
    t_res        n_res;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  rdata;
    logic [15:0] tpu;
    logic        stop_act;
    t_stage      aft, go_s;
    t_phase      cur;
    logic        halt;

    // buffer read address tracks the next byte to send
    assign raddr = AW'((r_stage == S_WDATA || r_stage == S_ACK_DATA) ?
                       r_byte + 8'd1 : r_byte);
    i2cm_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_item.data_byte),
        .i_raddr(raddr), .o_rdata(rdata));

    assign tpu = (i_tpu == 16'd0) ? 16'd1 : i_tpu;

    function automatic logic [7:0] rdata_sel(input logic [7:0] idx);
        rdata_sel = (32'(idx) < WRITE_DEPTH) ? rdata : 8'd0;
    endfunction

    always_comb begin
        n_phase = r_phase; n_stage = r_stage; n_resume = r_resume;
        n_bit = r_bit; n_byte = r_byte; n_shift = r_shift; n_poll = r_poll;
        n_timer = r_timer; n_delay = r_delay; n_load = r_load; n_dev = r_dev;
        n_reg = r_reg; n_len = r_len; n_rd = r_rd; n_scl = r_scl; n_sda = r_sda;
        n_fail = r_fail;
        n_res = '0;
        we = 1'b0;
        waddr = AW'(r_load);
        stop_act = 1'b0;
        aft = S_STOP; go_s = S_STOP;
        cur = r_phase;
        halt = 1'b0;
        if (i_go) begin
            if (i_item.kind == K_TICK) begin
                if (r_phase != P_IDLE) begin
                    // sequencer chain: each act that waits ends the tick
                    if (n_delay != 3'd0) begin
                        n_timer = r_timer + 16'd1;
                        if (n_timer >= tpu) begin
                            n_timer = '0;
                            n_delay = r_delay - 3'd1;
                        end
                    end
                    for (int j = 0; j < 4; j++) begin
                        if (!halt && n_phase != P_IDLE && n_delay == 3'd0) begin
                            cur = n_phase;
                            aft = S_STOP; go_s = S_STOP; stop_act = 1'b0;
                            case (n_phase)
                                P_START_HI: begin n_sda = 1'b0; n_delay = 3'd4;
                                    n_timer = '0; n_phase = P_START_LO; end
                                P_START_LO: begin n_scl = 1'b0; aft = n_stage; end
                                P_BIT_SET: begin n_scl = 1'b1; n_delay = 3'd2;
                                    n_timer = '0; n_phase = P_BIT_HIGH; end
                                P_BIT_HIGH: begin n_scl = 1'b0; n_delay = 3'd2;
                                    n_timer = '0; n_phase = P_BIT_LOW; end
                                P_BIT_LOW: begin
                                    n_bit = n_bit + 4'd1;
                                    if (n_bit < 4'd8) begin
                                        n_sda = n_shift[3'(4'd7 - n_bit)];
                                        n_delay = 3'd2; n_timer = '0;
                                        n_phase = P_BIT_SET;
                                    end else aft = n_stage;
                                end
                                P_ACK_REL: begin n_scl = 1'b1; n_delay = 3'd1;
                                    n_timer = '0; n_phase = P_ACK_RISE; end
                                P_ACK_RISE: begin n_poll = '0; n_phase = P_ACK_POLL; end
                                P_ACK_POLL: begin
                                    if (!i_item.sda_in) begin
                                        n_scl = 1'b0; aft = n_stage;
                                    end else if (n_poll >= i_ato) begin
                                        stop_act = 1'b1;
                                        if (n_stage == S_ACK_ADDR ||
                                            n_stage == S_ACK_DATA) begin
                                            n_fail = 1'b1; n_resume = S_STOP;
                                        end else n_resume = n_stage;
                                    end else n_poll = n_poll + 8'd1;
                                end
                                P_RD_LOW: begin
                                    n_scl = 1'b1;
                                    n_shift = {n_shift[6:0], i_item.sda_in};
                                    n_delay = 3'd1; n_timer = '0; n_phase = P_RD_HIGH;
                                end
                                P_RD_HIGH: begin
                                    n_bit = n_bit + 4'd1;
                                    if (n_bit < 4'd8) begin
                                        n_scl = 1'b0; n_delay = 3'd2; n_timer = '0;
                                        n_phase = P_RD_LOW;
                                    end else begin
                                        n_res.rvalid = 1'b1; n_res.rbyte = n_shift;
                                        aft = n_stage;
                                    end
                                end
                                P_AK_SET: begin n_scl = 1'b1; n_delay = 3'd2;
                                    n_timer = '0; n_phase = P_AK_HIGH; end
                                P_AK_HIGH: begin n_scl = 1'b0; aft = n_stage; end
                                P_STOP_LO: begin n_scl = 1'b1; n_sda = 1'b1;
                                    n_delay = 3'd4; n_timer = '0; n_phase = P_STOP_HI; end
                                P_STOP_HI: aft = S_STOP;
                                default: n_phase = P_IDLE;
                            endcase
                            // resume after a stop: one level of indirection
                            if (cur == P_STOP_HI || aft != S_STOP) begin
                                if (aft == S_STOP) begin
                                    if (n_resume == S_STOP) begin
                                        n_phase = P_IDLE; n_delay = '0;
                                        n_res.done = 1'b1;
                                        n_res.err = n_fail;
                                    end else aft = n_resume;
                                end
                                if (aft != S_STOP) begin
                                    case (aft)
                                        S_START1:    go_s = S_ADDR_W;
                                        S_ADDR_W:    go_s = S_ACK_ADDR;
                                        S_ACK_ADDR:  go_s = S_REG;
                                        S_REG:       go_s = S_ACK_REG;
                                        S_ACK_REG:   go_s = r_rd ? S_START2 :
                                            (n_byte < n_len ? S_WDATA : S_STOP);
                                        S_WDATA:     go_s = S_ACK_DATA;
                                        S_ACK_DATA: begin n_byte = n_byte + 8'd1;
                                            go_s = n_byte < n_len ? S_WDATA : S_STOP; end
                                        S_START2:    go_s = S_ADDR_R;
                                        S_ADDR_R:    go_s = S_ACK_RADDR;
                                        S_ACK_RADDR: go_s = n_byte < n_len ? S_RDATA : S_STOP;
                                        S_RDATA:     go_s = S_RACK;
                                        S_RACK: begin n_byte = n_byte + 8'd1;
                                            go_s = n_byte < n_len ? S_RDATA : S_STOP; end
                                        default:     go_s = S_STOP;
                                    endcase
                                    if (go_s == S_STOP) begin
                                        stop_act = 1'b1; n_resume = S_STOP;
                                    end
                                end
                            end
                            if (stop_act) begin
                                n_stage = S_STOP; n_scl = 1'b0; n_sda = 1'b0;
                                n_delay = 3'd4; n_timer = '0; n_phase = P_STOP_LO;
                            end else if (go_s != S_STOP) begin
                                n_stage = go_s; n_timer = '0;
                                case (go_s)
                                    S_ADDR_W, S_REG, S_WDATA, S_ADDR_R: begin
                                        case (go_s)
                                            S_ADDR_W: n_shift = {r_dev, 1'b0};
                                            S_REG:    n_shift = r_reg;
                                            S_ADDR_R: n_shift = {r_dev, 1'b1};
                                            default:  n_shift = rdata_sel(n_byte);
                                        endcase
                                        n_bit = '0; n_scl = 1'b0; n_sda = n_shift[7];
                                        n_delay = 3'd2; n_phase = P_BIT_SET;
                                    end
                                    S_START2: begin n_scl = 1'b1; n_sda = 1'b1;
                                        n_delay = 3'd4; n_phase = P_START_HI; end
                                    S_RDATA: begin n_bit = '0; n_shift = '0;
                                        n_scl = 1'b0; n_sda = 1'b1; n_delay = 3'd2;
                                        n_phase = P_RD_LOW; end
                                    S_RACK: begin n_scl = 1'b0;
                                        n_sda = (9'(n_byte) + 9'd1 < 9'(n_len)) ? 1'b0 : 1'b1;
                                        n_delay = 3'd2; n_phase = P_AK_SET; end
                                    default: begin n_sda = 1'b1; n_delay = 3'd1;
                                        n_phase = P_ACK_REL; end
                                endcase
                            end
                            if (cur == P_ACK_POLL) halt = 1'b1;
                        end
                    end
                end
            end else if (r_phase == P_IDLE) begin
                if (i_item.kind == K_LOAD) begin
                    if (32'(r_load) < WRITE_DEPTH) begin
                        we = 1'b1;
                        n_load = r_load + CW'(1);
                    end
                end else begin
                    n_dev = i_item.dev_addr; n_reg = i_item.reg_addr;
                    n_len = i_item.length;
                    n_rd = i_item.kind == K_READ;
                    if (!n_rd) begin
                        if (32'(n_len) > WRITE_DEPTH) n_len = 8'(WRITE_DEPTH);
                        n_load = '0;
                    end
                    n_byte = '0; n_fail = 1'b0; n_resume = S_STOP;
                    n_stage = S_START1; n_scl = 1'b1; n_sda = 1'b1;
                    n_delay = 3'd4; n_timer = '0; n_phase = P_START_HI;
                end
            end
        end
        n_res.scl = n_scl; n_res.sda = n_sda; n_res.busy = n_phase != P_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE; r_stage <= S_START1; r_resume <= S_STOP;
            r_bit <= '0; r_byte <= '0; r_shift <= '0; r_poll <= '0;
            r_timer <= '0; r_delay <= '0; r_load <= '0; r_dev <= '0;
            r_reg <= '0; r_len <= '0; r_rd <= 1'b0; r_scl <= 1'b1;
            r_sda <= 1'b1; r_fail <= 1'b0; o_res <= '0;
        end else begin
            r_phase <= n_phase; r_stage <= n_stage; r_resume <= n_resume;
            r_bit <= n_bit; r_byte <= n_byte; r_shift <= n_shift; r_poll <= n_poll;
            r_timer <= n_timer; r_delay <= n_delay; r_load <= n_load; r_dev <= n_dev;
            r_reg <= n_reg; r_len <= n_len; r_rd <= n_rd; r_scl <= n_scl;
            r_sda <= n_sda; r_fail <= n_fail;
            if (i_go) o_res <= n_res;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/i2c_master_register_access.sv =====
// -----------------------------------------------------------------------------
// i2c_master_register_access
// Register-addressed I2C master, one result per transaction.
// -----------------------------------------------------------------------------
// One transaction per clock while the output is not stalled: accepted items enter a
// two-entry queue, the bus engine retires one per cycle into an output register, and
// the result appears in the cycle after the engine takes the item. Throughput is set by
// the engine step, one item per clock, limited only by output stall.
`default_nettype none
module i2c_master_register_access #(
    parameter int WRITE_DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_kind,
    input  wire logic [6:0] i_dev_addr,
    input  wire logic [7:0] i_reg_addr,
    input  wire logic [7:0] i_length,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_sda_in,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_scl_level,
    output logic            o_sda_level,
    output logic [7:0]      o_read_byte,
    output logic            o_read_valid,
    output logic            o_busy_res,
    output logic            o_done_res,
    output logic            o_error
);
    import i2cm_pkg::*;
    `include "i2c_master_register_access_assert.svh"

    logic [15:0] r_tpu;
    logic [7:0]  r_ato;
    t_item       in_item, q_item;
    t_res        res;
    logic        q_valid, q_full, push, pop, r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu <= 16'd1; r_ato <= 8'd250;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TPU) r_tpu <= i_cfg_data;
            else r_ato <= i_cfg_data[7:0];
        end
    end

    assign in_item = '{kind: i_kind, dev_addr: i_dev_addr, reg_addr: i_reg_addr,
                       length: i_length, data_byte: i_data_byte, sda_in: i_sda_in};
    assign o_stall = q_full;
    assign push = i_valid && !q_full;
    assign pop  = q_valid && (!r_ov || !i_stall);

    i2cm_queue u_queue (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push),
        .i_item(in_item), .i_pop(pop), .o_valid(q_valid), .o_full(q_full),
        .o_item(q_item));

    i2cm_engine #(.WRITE_DEPTH(WRITE_DEPTH)) u_engine (.i_clk(i_clk),
        .i_rst_n(i_rst_n), .i_go(pop), .i_item(q_item), .i_tpu(r_tpu),
        .i_ato(r_ato), .o_res(res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (pop) r_ov <= 1'b1;
        else if (!i_stall) r_ov <= 1'b0;
    end

    assign o_valid = r_ov;
    assign o_scl_level = res.scl;
    assign o_sda_level = res.sda;
    assign o_read_byte = res.rbyte;
    assign o_read_valid = res.rvalid;
    assign o_busy_res = res.busy;
    assign o_done_res = res.done;
    assign o_error = res.err;

    `I2CM_ASSERT_IMPL(a_err_done, o_valid && o_error, o_done_res)
    `I2CM_ASSERT_IMPL(a_done_idle, o_valid && o_done_res, !o_busy_res)
    `I2CM_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(res))
endmodule
`default_nettype wire

// ===== tb/i2c_master_register_access_test.sv =====
// -----------------------------------------------------------------------------
// i2c_master_register_access_test
// Self-checking testbench for the register-addressed I2C master. A cycle-free
// model of the bus engine predicts one result per accepted transaction; a
// checker compares every returned result with the oldest prediction. Directed
// tests cover the buffer limits, zero length, reads, acknowledge
// timeouts and timing extremes. Random transfers follow, with ignored items
// mixed in and random idling on both channels.
// -----------------------------------------------------------------------------
`default_nettype none
module i2c_master_register_access_test;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cm_pkg::*;

    localparam int DEPTH = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = K_TICK;
    logic [6:0]  i_dev_addr = '0;
    logic [7:0]  i_reg_addr = '0;
    logic [7:0]  i_length = '0;
    logic [7:0]  i_data_byte = '0;
    logic        i_sda_in = 1'b1;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_scl_level, o_sda_level, o_read_valid, o_busy_res, o_done_res, o_error;
    logic [7:0]  o_read_byte;

    i2c_master_register_access #(.WRITE_DEPTH(DEPTH)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // bus engine model state
    t_phase      ph;
    t_stage      stg, resume;
    int unsigned bcnt, bytec, utimer, dleft, polls, lcnt, slen;
    logic [7:0]  shreg, regv;
    logic [6:0]  dev;
    logic [7:0]  wbuf [DEPTH];
    bit          rd, scl, sda, failed, o_v, o_d;
    logic [7:0]  o_b;
    int unsigned tpu, ato;

    t_res        expected_q [$];
    int          errors = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;
    bit [15:0]   nack_mask = '0;
    bit          ack_noise = 1'b0;

    function automatic void bus_wait(int unsigned n, t_phase nx);
        dleft = n;
        utimer = 0;
        ph = nx;
    endfunction

    function automatic void start_cond();
        scl = 1'b1; sda = 1'b1;
        bus_wait(4, P_START_HI);
    endfunction

    function automatic void send_byte(logic [7:0] b);
        shreg = b; bcnt = 0; scl = 1'b0; sda = b[7];
        bus_wait(2, P_BIT_SET);
    endfunction

    function automatic void stop_cond(t_stage r);
        resume = r; stg = S_STOP; scl = 1'b0; sda = 1'b0;
        bus_wait(4, P_STOP_LO);
    endfunction

    function automatic void enter(t_stage s);
        stg = s;
        case (s)
            S_ADDR_W: send_byte({dev, 1'b0});
            S_REG:    send_byte(regv);
            S_WDATA:  send_byte(bytec < DEPTH ? wbuf[bytec] : 8'h00);
            S_START2: start_cond();
            S_ADDR_R: send_byte({dev, 1'b1});
            S_RDATA: begin
                bcnt = 0; shreg = 8'h00; scl = 1'b0; sda = 1'b1;
                bus_wait(2, P_RD_LOW);
            end
            S_RACK: begin
                scl = 1'b0; sda = (bytec + 1 < slen) ? 1'b0 : 1'b1;
                bus_wait(2, P_AK_SET);
            end
            default: begin
                sda = 1'b1;
                bus_wait(1, P_ACK_REL);
            end
        endcase
    endfunction

    function automatic void data_or_stop(t_stage ds);
        if (bytec < slen) enter(ds);
        else stop_cond(S_STOP);
    endfunction

    function automatic void advance(t_stage s);
        case (s)
            S_START1:    enter(S_ADDR_W);
            S_ADDR_W:    enter(S_ACK_ADDR);
            S_ACK_ADDR:  enter(S_REG);
            S_REG:       enter(S_ACK_REG);
            S_ACK_REG:   if (rd) enter(S_START2); else data_or_stop(S_WDATA);
            S_WDATA:     enter(S_ACK_DATA);
            S_ACK_DATA: begin bytec++; data_or_stop(S_WDATA); end
            S_START2:    enter(S_ADDR_R);
            S_ADDR_R:    enter(S_ACK_RADDR);
            S_ACK_RADDR: data_or_stop(S_RDATA);
            S_RDATA:     enter(S_RACK);
            S_RACK:     begin bytec++; data_or_stop(S_RDATA); end
            default: begin
                if (resume == S_STOP) begin
                    ph = P_IDLE; dleft = 0; o_d = 1'b1;
                end else begin
                    advance(resume);
                end
            end
        endcase
    endfunction

    function automatic bit bus_action(bit sin);
        case (ph)
            P_START_HI: begin sda = 1'b0; bus_wait(4, P_START_LO); end
            P_START_LO: begin scl = 1'b0; advance(stg); end
            P_BIT_SET:  begin scl = 1'b1; bus_wait(2, P_BIT_HIGH); end
            P_BIT_HIGH: begin scl = 1'b0; bus_wait(2, P_BIT_LOW); end
            P_BIT_LOW: begin
                bcnt++;
                if (bcnt < 8) begin
                    sda = shreg[7 - bcnt];
                    bus_wait(2, P_BIT_SET);
                end else advance(stg);
            end
            P_ACK_REL:  begin scl = 1'b1; bus_wait(1, P_ACK_RISE); end
            P_ACK_RISE: begin polls = 0; ph = P_ACK_POLL; end
            P_ACK_POLL: begin
                if (!sin) begin
                    scl = 1'b0; advance(stg);
                end else if (polls >= ato) begin
                    if (stg == S_ACK_ADDR || stg == S_ACK_DATA) begin
                        failed = 1'b1; stop_cond(S_STOP);
                    end else stop_cond(stg);
                end else polls++;
                return 1'b1;
            end
            P_RD_LOW: begin
                scl = 1'b1; shreg = {shreg[6:0], sin};
                bus_wait(1, P_RD_HIGH);
            end
            P_RD_HIGH: begin
                bcnt++;
                if (bcnt < 8) begin
                    scl = 1'b0; bus_wait(2, P_RD_LOW);
                end else begin
                    o_v = 1'b1; o_b = shreg; advance(stg);
                end
            end
            P_AK_SET:   begin scl = 1'b1; bus_wait(2, P_AK_HIGH); end
            P_AK_HIGH:  begin scl = 1'b0; advance(stg); end
            P_STOP_LO:  begin scl = 1'b1; sda = 1'b1; bus_wait(4, P_STOP_HI); end
            P_STOP_HI:  advance(S_STOP);
            default: begin ph = P_IDLE; return 1'b1; end
        endcase
        return 1'b0;
    endfunction

    function automatic void bus_tick(bit sin);
        int unsigned eff;
        if (ph == P_IDLE) return;
        if (dleft > 0) begin
            eff = (tpu == 0) ? 1 : tpu;
            utimer++;
            if (utimer >= eff) begin
                utimer = 0; dleft--;
            end
            if (dleft > 0) return;
        end
        for (int g = 0; g < 32; g++) begin
            if (ph == P_IDLE || dleft > 0) break;
            if (bus_action(sin)) break;
        end
    endfunction

    function automatic t_res predict_bus(t_item it);
        t_res r;
        o_v = 1'b0; o_d = 1'b0; o_b = 8'h00;
        if (it.kind == K_TICK) begin
            bus_tick(it.sda_in);
        end else if (ph == P_IDLE) begin
            if (it.kind == K_LOAD) begin
                if (lcnt < DEPTH) begin
                    wbuf[lcnt] = it.data_byte; lcnt++;
                end
            end else begin
                dev = it.dev_addr; regv = it.reg_addr; slen = it.length;
                rd = (it.kind == K_READ);
                if (!rd) begin
                    if (slen > DEPTH) slen = DEPTH;
                    lcnt = 0;
                end
                bytec = 0; failed = 1'b0; resume = S_STOP; stg = S_START1;
                start_cond();
            end
        end
        r.scl = scl; r.sda = sda;
        r.rbyte = o_v ? o_b : 8'h00;
        r.rvalid = o_v;
        r.busy = (ph != P_IDLE);
        r.done = o_d;
        r.err = o_d && failed;
        return r;
    endfunction

    task automatic send_item(t_item it);
        while (!calm && $urandom_range(99) < 12) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind = it.kind; i_dev_addr = it.dev_addr; i_reg_addr = it.reg_addr;
        i_length = it.length; i_data_byte = it.data_byte; i_sda_in = it.sda_in;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.push_back(predict_bus(it));
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_item rand_item(logic [1:0] k);
        t_item it;
        it.kind = k;
        it.dev_addr = 7'($urandom_range(127));
        it.reg_addr = 8'($urandom_range(255));
        it.length = 8'($urandom_range(255));
        it.data_byte = 8'($urandom_range(255));
        it.sda_in = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic settle();
        i_valid = 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        settle();
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_TPU) tpu = val;
        else ato = val[7:0];
    endtask

    task automatic load_byte(logic [7:0] b);
        t_item it;
        it = rand_item(K_LOAD);
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic begin_xfer(logic [1:0] k, logic [7:0] len);
        t_item it;
        it = rand_item(k);
        it.length = len;
        send_item(it);
    endtask

    // ticks until the transfer ends; acks follow nack_mask and ack_noise
    task automatic run_bus(bit noisy);
        t_item it;
        while (ph != P_IDLE) begin
            if (noisy && $urandom_range(99) < 4) begin
                it = rand_item(2'($urandom_range(1, 3)));
            end else begin
                it = rand_item(K_TICK);
                if (ph inside {P_ACK_REL, P_ACK_RISE, P_ACK_POLL})
                    it.sda_in = nack_mask[stg] ? 1'b1 :
                                (ack_noise ? ($urandom_range(3) == 0) : 1'b0);
            end
            send_item(it);
        end
    endtask

    task automatic test_buffer_limits();
        load_byte(8'h00);
        load_byte(8'hFF);
        for (int i = 2; i < DEPTH + 2; i++) load_byte(8'($urandom_range(255)));
        begin_xfer(K_WRITE, 8'd0);
        run_bus(1'b0);
        load_byte(8'hA5);
        begin_xfer(K_WRITE, 8'd1);
        run_bus(1'b1);
    endtask

    task automatic test_zero_length();
        begin_xfer(K_WRITE, 8'd0);
        run_bus(1'b0);
        begin_xfer(K_READ, 8'd0);
        run_bus(1'b0);
    endtask

    task automatic test_reads();
        calm = 1'b1;
        begin_xfer(K_READ, 8'd2);
        run_bus(1'b0);
        calm = 1'b0;
    endtask

    task automatic test_timeouts();
        write_cfg(CFG_ATO, 16'h0000);
        nack_mask = '0; nack_mask[S_ACK_ADDR] = 1'b1;
        begin_xfer(K_WRITE, 8'd2);
        run_bus(1'b0);
        nack_mask = '0; nack_mask[S_ACK_DATA] = 1'b1;
        begin_xfer(K_WRITE, 8'd2);
        run_bus(1'b0);
        nack_mask = '0; nack_mask[S_ACK_REG] = 1'b1; nack_mask[S_ACK_RADDR] = 1'b1;
        begin_xfer(K_READ, 8'd1);
        run_bus(1'b0);
        write_cfg(CFG_ATO, 16'h0003);
        nack_mask = '0; nack_mask[S_ACK_ADDR] = 1'b1;
        begin_xfer(K_WRITE, 8'd1);
        run_bus(1'b0);
        nack_mask = '0;
        write_cfg(CFG_ATO, 16'd250);
    endtask

    task automatic test_timing_extremes();
        write_cfg(CFG_TPU, 16'h0000);
        begin_xfer(K_WRITE, 8'd0);
        run_bus(1'b1);
        write_cfg(CFG_TPU, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_item(rand_item(K_TICK));
        write_cfg(CFG_TPU, 16'd1);
    endtask

    task automatic test_random();
        int n;
        int rounds;
        rounds = 0;
        calm = 1'b0;
        while (rounds < 2 || items_sent < 1350) begin
            rounds++;
            if ($urandom_range(3) == 0) begin
                write_cfg(CFG_TPU, 16'($urandom_range(3)));
                write_cfg(CFG_ATO, {8'($urandom_range(255)), ($urandom_range(9) == 0) ?
                          8'($urandom_range(255)) : 8'($urandom_range(4))});
            end
            ack_noise = 1'($urandom_range(1));
            nack_mask = '0;
            if ($urandom_range(7) == 0)
                nack_mask[$urandom_range(1) ? S_ACK_ADDR : S_ACK_DATA] = 1'b1;
            if ($urandom_range(7) == 0)
                nack_mask[$urandom_range(1) ? S_ACK_REG : S_ACK_RADDR] = 1'b1;
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) send_item(rand_item($urandom_range(4) == 0 ? K_TICK : K_LOAD));
            if ($urandom_range(9) == 0) continue;
            begin_xfer($urandom_range(1) ? K_WRITE : K_READ,
                       8'(($urandom_range(19) == 0) ? $urandom_range(16) : $urandom_range(4)));
            run_bus(1'b1);
        end
        calm = 1'b0;
        nack_mask = '0;
    endtask

    // result checker and output stall
    initial begin
        t_res exp_r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction");
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (o_scl_level !== exp_r.scl) begin
                        $error("scl_level exp %0d got %0d", exp_r.scl, o_scl_level); errors++;
                    end
                    if (o_sda_level !== exp_r.sda) begin
                        $error("sda_level exp %0d got %0d", exp_r.sda, o_sda_level); errors++;
                    end
                    if (o_read_byte !== exp_r.rbyte) begin
                        $error("read_byte exp %0h got %0h", exp_r.rbyte, o_read_byte); errors++;
                    end
                    if (o_read_valid !== exp_r.rvalid) begin
                        $error("read_valid exp %0d got %0d", exp_r.rvalid, o_read_valid); errors++;
                    end
                    if (o_busy_res !== exp_r.busy) begin
                        $error("busy_res exp %0d got %0d", exp_r.busy, o_busy_res); errors++;
                    end
                    if (o_done_res !== exp_r.done) begin
                        $error("done_res exp %0d got %0d", exp_r.done, o_done_res); errors++;
                    end
                    if (o_error !== exp_r.err) begin
                        $error("error exp %0d got %0d", exp_r.err, o_error); errors++;
                    end
                end
            end
            @(negedge i_clk);
            i_stall = !calm && ($urandom_range(99) < 12);
        end
    end

    initial begin
        tpu = 1; ato = 250;
        ph = P_IDLE; stg = S_START1; resume = S_STOP;
        bcnt = 0; bytec = 0; utimer = 0; dleft = 0; polls = 0; lcnt = 0; slen = 0;
        shreg = 8'h00; regv = 8'h00; dev = 7'h00; rd = 1'b0; scl = 1'b1; sda = 1'b1;
        failed = 1'b0;
        foreach (wbuf[i]) wbuf[i] = 8'h00;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_buffer_limits();
        test_zero_length();
        test_reads();
        test_timeouts();
        test_timing_extremes();
        test_random();

        settle();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_ram.sv
hw/rtl/i2cm_queue.sv
hw/rtl/i2cm_engine.sv
hw/rtl/i2c_master_register_access.sv
tb/i2c_master_register_access_test.sv
